>>> hdl/fplog_pkg.sv
// Shared widths, constants, series coefficients and types of the fixed-point logarithm.
`default_nettype none
package fplog_pkg;
   localparam int SAMPLE_W    = 32;
   localparam int LOG_W       = 32;
   localparam int SCALE_W     = 32;
   localparam int SCALE_FRAC  = 24;
   localparam int Q15_W       = 16;
   localparam int FRAC_W      = 16;
   localparam int ACC_W       = 23;
   localparam int MAG_W       = 31;
   localparam int SHIFT_W     = 5;
   localparam int COEF_SHIFT  = 13;
   localparam int POWER_SHIFT = 15;
   localparam int COEF_COUNT  = 10;
   localparam int SERIES_TERMS_DEFAULT = 10;

   localparam logic signed [Q15_W-1:0] ONE_Q15 = 16'sh7FFF;
   localparam logic signed [Q15_W-1:0] NORM_U_MIN = -16'sh3FFF;
   localparam logic signed [SCALE_W-1:0] BASE_SCALE_RESET = 32'sh0100_0000;

   localparam logic signed [Q15_W-1:0] SERIES_COEF [COEF_COUNT] = '{
      16'sd23637, -16'sd11819, 16'sd7879, -16'sd5909, 16'sd4727,
      -16'sd3940, 16'sd3377, -16'sd2955, 16'sd2626, -16'sd2364
   };

   typedef struct packed {
      logic signed [Q15_W-1:0] u;
      logic signed [Q15_W-1:0] power;
      logic signed [ACC_W-1:0] acc;
   } cell_type;
endpackage
`default_nettype wire

>>> hdl/fplog_norm.sv
// Magnitude and three-stage normalization that seeds the series chain.
`default_nettype none
module fplog_norm (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic signed [fplog_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                         out_valid,
   input  wire logic                                    out_ready,
   output fplog_pkg::cell_type                          out_data
);
   localparam int MAG_W   = fplog_pkg::MAG_W;
   localparam int SHIFT_W = fplog_pkg::SHIFT_W;
   localparam int ACC_W   = fplog_pkg::ACC_W;
   localparam int Q15_W   = fplog_pkg::Q15_W;
   localparam logic signed [ACC_W-1:0] ZERO_ACC = -ACC_W'(31 * 65536);

   logic                 m_valid_ff, m_valid_in, m_ready;
   logic [MAG_W-1:0]     m_mag_ff, m_mag_in, mag;
   logic                 a_valid_ff, a_valid_in, a_ready;
   logic [MAG_W-1:0]     a_v_ff, a_v_in, v16;
   logic [SHIFT_W-1:0]   a_cnt_ff, a_cnt_in, c16;
   logic                 b_valid_ff, b_valid_in, b_ready;
   fplog_pkg::cell_type  b_data_ff, b_data_in;
   logic [MAG_W-1:0]     v4, v2, v1;
   logic [SHIFT_W-1:0]   c4, c2, c1;
   logic signed [Q15_W-1:0] u;

   always_comb begin
      if (req_sample[fplog_pkg::SAMPLE_W-1]) begin
         if (req_sample[MAG_W-1:0] == '0) begin
            mag = '1;
         end else begin
            mag = MAG_W'(~req_sample + 1'b1);
         end
      end else begin
         mag = req_sample[MAG_W-1:0];
      end
   end

   assign b_ready   = !b_valid_ff || out_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign m_ready   = !m_valid_ff || a_ready;
   assign req_ready = m_ready;

   always_comb begin
      m_valid_in = m_ready ? req_valid : m_valid_ff;
      m_mag_in   = (m_ready && req_valid) ? mag : m_mag_ff;
   end

   always_comb begin
      if (m_mag_ff[MAG_W-1 -: 16] == '0) begin
         v16 = m_mag_ff << 16;
         c16 = SHIFT_W'(16);
      end else begin
         v16 = m_mag_ff;
         c16 = '0;
      end
      a_valid_in = a_ready ? m_valid_ff : a_valid_ff;
      a_v_in     = a_v_ff;
      a_cnt_in   = a_cnt_ff;
      if (a_ready && m_valid_ff) begin
         if (v16[MAG_W-1 -: 8] == '0) begin
            a_v_in   = v16 << 8;
            a_cnt_in = c16 + SHIFT_W'(8);
         end else begin
            a_v_in   = v16;
            a_cnt_in = c16;
         end
      end
   end

   always_comb begin
      v4 = (a_v_ff[MAG_W-1 -: 4] == '0) ? (a_v_ff << 4) : a_v_ff;
      c4 = (a_v_ff[MAG_W-1 -: 4] == '0) ? (a_cnt_ff + SHIFT_W'(4)) : a_cnt_ff;
      v2 = (v4[MAG_W-1 -: 2] == '0) ? (v4 << 2) : v4;
      c2 = (v4[MAG_W-1 -: 2] == '0) ? (c4 + SHIFT_W'(2)) : c4;
      v1 = (!v2[MAG_W-1]) ? (v2 << 1) : v2;
      c1 = (!v2[MAG_W-1]) ? (c2 + SHIFT_W'(1)) : c2;
      u  = $signed({1'b0, v1[MAG_W-1 -: Q15_W-1]}) - fplog_pkg::ONE_Q15;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_data_in  = b_data_ff;
      if (b_ready && a_valid_ff) begin
         b_data_in.u     = u;
         b_data_in.power = u;
         b_data_in.acc   = ACC_W'(0) - ACC_W'({c1, {fplog_pkg::FRAC_W{1'b0}}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_mag_ff  <= m_mag_in;
      a_v_ff    <= a_v_in;
      a_cnt_ff  <= a_cnt_in;
      b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

`ifndef ASSERT_OFF
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_data_ff.u != -fplog_pkg::ONE_Q15) |->
      (b_data_ff.u >= fplog_pkg::NORM_U_MIN && b_data_ff.u <= 0))
      else $error("normalized fraction out of range");
   a_zero_acc: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_data_ff.u == -fplog_pkg::ONE_Q15) |-> (b_data_ff.acc == ZERO_ACC))
      else $error("zero magnitude did not give the full shift count");
`endif
endmodule
`default_nettype wire

>>> hdl/fplog_cell.sv
// One series cell: adds its coefficient term and raises the power for the next cell.
`default_nettype none
module fplog_cell #(
   parameter int TERM = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire fplog_pkg::cell_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output fplog_pkg::cell_type       out_data
);
   localparam int Q15_W  = fplog_pkg::Q15_W;
   localparam int PROD_W = 2 * Q15_W;
   localparam logic signed [Q15_W-1:0] COEF = fplog_pkg::SERIES_COEF[TERM];

   logic                 valid_ff, valid_in;
   fplog_pkg::cell_type  data_ff, data_in;
   logic signed [PROD_W-1:0] term_prod, power_prod, term_shift;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      term_prod  = in_data.power * COEF;
      power_prod = in_data.power * in_data.u;
      term_shift = term_prod >>> fplog_pkg::COEF_SHIFT;
      valid_in   = in_ready ? in_valid : valid_ff;
      data_in    = data_ff;
      if (in_ready && in_valid) begin
         data_in.u     = in_data.u;
         data_in.power = power_prod[fplog_pkg::POWER_SHIFT +: Q15_W];
         data_in.acc   = in_data.acc + fplog_pkg::ACC_W'(term_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`ifndef ASSERT_OFF
   a_cell_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (valid_ff && data_ff.u == $past(in_data.u)))
      else $error("series cell lost a transaction");
`endif
endmodule
`default_nettype wire

>>> hdl/fplog_scale.sv
// Output stage: multiplies the base-2 result by the conversion factor and holds the result.
`default_nettype none
module fplog_scale (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output logic                                        in_ready,
   input  wire logic signed [fplog_pkg::ACC_W-1:0]     in_acc,
   input  wire logic signed [fplog_pkg::SCALE_W-1:0]   base_scale,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [fplog_pkg::LOG_W-1:0]          rsp_log_value
);
   localparam int PROD_W = fplog_pkg::ACC_W + fplog_pkg::SCALE_W;

   logic                               valid_ff, valid_in;
   logic signed [fplog_pkg::LOG_W-1:0] log_ff, log_in;
   logic signed [PROD_W-1:0]           prod;
   logic        [PROD_W:0]             prod_ext;

   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      prod     = in_acc * base_scale;
      prod_ext = {prod[PROD_W-1], prod};
      valid_in = in_ready ? in_valid : valid_ff;
      log_in   = (in_ready && in_valid) ?
                 $signed(prod_ext[fplog_pkg::SCALE_FRAC +: fplog_pkg::LOG_W]) : log_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      log_ff <= log_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_log_value = log_ff;

`ifndef ASSERT_OFF
   a_scale_load: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> rsp_valid)
      else $error("scaled result not presented");
`endif
endmodule
`default_nettype wire

>>> hdl/fixed_point_log_taylor.sv
// Throughput: one transaction per cycle unless the result stalls; three normalization stages,
// one series cell per term and one scaling multiply stage each hand data on every cycle.
// A stalled result holds all full stages at once through the ready chain; empty stages still fill.
// Reset is synchronous: it empties every stage and sets base_scale to 1.0 (plain log2).
`default_nettype none
module fixed_point_log_taylor #(
   parameter int SERIES_TERMS = fplog_pkg::SERIES_TERMS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [fplog_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [fplog_pkg::LOG_W-1:0]          rsp_log_value,
   input  wire logic                                   csr_wr_en,
   input  wire logic signed [fplog_pkg::SCALE_W-1:0]   csr_wr_data
);
   logic signed [fplog_pkg::SCALE_W-1:0] base_scale_ff, base_scale_in;

   fplog_pkg::cell_type chain_data  [SERIES_TERMS+1];
   logic                chain_valid [SERIES_TERMS+1];
   logic                chain_ready [SERIES_TERMS+1];

   assign base_scale_in = csr_wr_en ? csr_wr_data : base_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_scale_ff <= fplog_pkg::BASE_SCALE_RESET;
      end else begin
         base_scale_ff <= base_scale_in;
      end
   end

   fplog_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .out_valid  (chain_valid[0]),
      .out_ready  (chain_ready[0]),
      .out_data   (chain_data[0])
   );

   for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_cell
      fplog_cell #(
         .TERM (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   fplog_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chain_valid[SERIES_TERMS]),
      .in_ready      (chain_ready[SERIES_TERMS]),
      .in_acc        (chain_data[SERIES_TERMS].acc),
      .base_scale    (base_scale_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_log_value (rsp_log_value)
   );
endmodule
`default_nettype wire
